[hw/rtl/rgbhsv_pkg.sv]
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared widths, defaults and codes for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int CHANNEL_BITS_DEF      = 8;
    localparam int HUE_FRACTION_BITS_DEF = 6;

    // Stream field widths
    localparam int IN_W      = 8;
    localparam int HUE_W     = 15;
    localparam int SAT_W     = 8;
    localparam int VAL_W     = 8;
    localparam int S_TDATA_W = 3 * IN_W;
    localparam int M_TDATA_W = 32;

    // Divider lanes
    localparam int LANES    = 2;
    localparam int LANE_SAT = 0;
    localparam int LANE_HUE = 1;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

endpackage

[hw/rtl/rgbhsv_div.sv]
// ----------------------------------------------------------------------------
// rgbhsv_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rgbhsv_div #(
    parameter int DW  = 8,
    parameter int QW  = 12,
    parameter int SBW = 8
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         ce,
    input  logic                                         in_valid,
    input  logic [rgbhsv_pkg::LANES-1:0][DW+QW-1:0]      in_num,
    input  logic [rgbhsv_pkg::LANES-1:0][DW-1:0]         in_den,
    input  logic [SBW-1:0]                               in_sb,
    output logic                                         out_valid,
    output logic [rgbhsv_pkg::LANES-1:0][QW-1:0]         out_quo,
    output logic [rgbhsv_pkg::LANES-1:0]                 out_rem_nz,
    output logic [SBW-1:0]                               out_sb
);

    localparam int LN = rgbhsv_pkg::LANES;

    logic [DW-1:0]  rem_reg  [LN][QW];
    logic [QW-1:0]  wrk_reg  [LN][QW];
    logic [DW-1:0]  den_reg  [LN][QW];
    logic [SBW-1:0] sb_reg   [QW];
    logic [QW-1:0]  vld_reg;

    logic [DW-1:0]  src_rem  [LN][QW];
    logic [QW-1:0]  src_wrk  [LN][QW];
    logic [DW-1:0]  src_den  [LN][QW];
    logic [DW:0]    trial    [LN][QW];
    logic           qbit     [LN][QW];
    logic [DW-1:0]  rem_next [LN][QW];
    logic [QW-1:0]  wrk_next [LN][QW];

    // Upper DW bits of the dividend seed the remainder; the low QW bits
    // shift out MSB first while quotient bits shift in at the bottom.
    always_comb begin
        for (int l = 0; l < LN; l++) begin
            src_rem[l][0] = in_num[l][DW+QW-1:QW];
            src_wrk[l][0] = in_num[l][QW-1:0];
            src_den[l][0] = in_den[l];
            for (int k = 1; k < QW; k++) begin
                src_rem[l][k] = rem_reg[l][k-1];
                src_wrk[l][k] = wrk_reg[l][k-1];
                src_den[l][k] = den_reg[l][k-1];
            end
            for (int k = 0; k < QW; k++) begin
                trial[l][k]    = {src_rem[l][k], src_wrk[l][k][QW-1]};
                qbit[l][k]     = (trial[l][k] >= {1'b0, src_den[l][k]});
                rem_next[l][k] = qbit[l][k] ? DW'(trial[l][k] - {1'b0, src_den[l][k]})
                                            : trial[l][k][DW-1:0];
                wrk_next[l][k] = {src_wrk[l][k][QW-2:0], qbit[l][k]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[QW-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sb_reg[0] <= in_sb;
            for (int k = 1; k < QW; k++) begin
                sb_reg[k] <= sb_reg[k-1];
            end
            for (int l = 0; l < LN; l++) begin
                for (int k = 0; k < QW; k++) begin
                    rem_reg[l][k] <= rem_next[l][k];
                    wrk_reg[l][k] <= wrk_next[l][k];
                    den_reg[l][k] <= src_den[l][k];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LN; l++) begin
            out_quo[l]    = wrk_reg[l][QW-1];
            out_rem_nz[l] = (rem_reg[l][QW-1] != '0);
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_sb    = sb_reg[QW-1];

endmodule

[hw/rtl/rgb_to_hsv_converter.sv]
// Input capture, stages 2 and 3, the quotient pipeline, stage 4 and the output
//   register lie between accept and result.
// One word per cycle while skid is empty; the whole pipe advances together.
// A two-entry output buffer lets one more word in after the sink stalls.
// Reset (synchronous, aresetn low) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Streaming RGB to HSV conversion, hue in 1/2^HUE_FRACTION_BITS degree units.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
    parameter int CHANNEL_BITS      = rgbhsv_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = rgbhsv_pkg::HUE_FRACTION_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // red, green, blue
    input  logic [rgbhsv_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // hue, saturation, value, zero pad
    output logic [rgbhsv_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // achromatic
    output logic [0:0]                       m_axis_tuser
);

    localparam int CB      = CHANNEL_BITS;
    localparam int S       = 1 << HUE_FRACTION_BITS;
    localparam int HQ      = $clog2(60 * S + 1);
    localparam int DS      = (CB > HQ) ? CB : HQ;
    localparam int NW      = CB + DS;
    localparam int HW      = $clog2(360 * S);
    localparam int FULL    = (1 << CB) - 1;
    localparam int SPAN    = 60 * S;
    localparam int IN_W    = rgbhsv_pkg::IN_W;
    localparam int HUE_W   = rgbhsv_pkg::HUE_W;
    localparam int SAT_W   = rgbhsv_pkg::SAT_W;
    localparam int VAL_W   = rgbhsv_pkg::VAL_W;
    localparam int OUT_W   = HUE_W + SAT_W + VAL_W;
    localparam int LN      = rgbhsv_pkg::LANES;
    localparam int L_SAT   = rgbhsv_pkg::LANE_SAT;
    localparam int L_HUE   = rgbhsv_pkg::LANE_HUE;

    localparam logic signed [HW:0] OFF_GREEN = (HW+1)'(120 * S);
    localparam logic signed [HW:0] OFF_BLUE  = (HW+1)'(240 * S);
    localparam logic signed [HW:0] WRAP      = (HW+1)'(360 * S);

    typedef struct packed {
        logic [CB-1:0]       mx;
        rgbhsv_pkg::sector_t sec;
        logic                neg;
        logic                gray;
    } side_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [SAT_W-1:0] sat;
        logic [HUE_W-1:0] hue;
        logic             achrom;
    } res_t;

    logic ce;

    // ---------------- stage 1: input capture
    logic          v1_reg;
    logic [CB-1:0] r1_reg, g1_reg, b1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            r1_reg <= CB'(s_axis_tdata[IN_W-1:0]);
            g1_reg <= CB'(s_axis_tdata[2*IN_W-1:IN_W]);
            b1_reg <= CB'(s_axis_tdata[3*IN_W-1:2*IN_W]);
        end
    end

    // ---------------- stage 2: max, min, sector, signed difference
    logic                v2_reg;
    logic [CB-1:0]       mx2_reg, dl2_reg, mag2_reg;
    rgbhsv_pkg::sector_t sec2_reg;
    logic                neg2_reg;

    logic [CB-1:0]       mx_w, mn_w, opx_w, opy_w;
    rgbhsv_pkg::sector_t sec_w;

    always_comb begin
        mx_w = r1_reg;
        mn_w = r1_reg;
        if (g1_reg > mx_w) mx_w = g1_reg;
        if (b1_reg > mx_w) mx_w = b1_reg;
        if (g1_reg < mn_w) mn_w = g1_reg;
        if (b1_reg < mn_w) mn_w = b1_reg;
        // ties go to red, then green
        priority if (r1_reg >= g1_reg && r1_reg >= b1_reg) begin
            sec_w = rgbhsv_pkg::SEC_RED;
            opx_w = g1_reg;
            opy_w = b1_reg;
        end else if (g1_reg >= b1_reg) begin
            sec_w = rgbhsv_pkg::SEC_GREEN;
            opx_w = b1_reg;
            opy_w = r1_reg;
        end else begin
            sec_w = rgbhsv_pkg::SEC_BLUE;
            opx_w = r1_reg;
            opy_w = g1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mx2_reg  <= mx_w;
            dl2_reg  <= mx_w - mn_w;
            sec2_reg <= sec_w;
            neg2_reg <= (opx_w < opy_w);
            mag2_reg <= (opx_w < opy_w) ? (opy_w - opx_w) : (opx_w - opy_w);
        end
    end

    // ---------------- stage 3: scaled dividends
    logic                         v3_reg;
    logic [LN-1:0][NW-1:0]        num3_reg;
    logic [LN-1:0][CB-1:0]        den3_reg;
    side_t                        sb3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ce) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            num3_reg[L_SAT] <= NW'(dl2_reg) * NW'(FULL);
            num3_reg[L_HUE] <= NW'(mag2_reg) * NW'(SPAN);
            den3_reg[L_SAT] <= mx2_reg;
            den3_reg[L_HUE] <= dl2_reg;
            sb3_reg.mx      <= mx2_reg;
            sb3_reg.sec     <= sec2_reg;
            sb3_reg.neg     <= neg2_reg;
            sb3_reg.gray    <= (dl2_reg == '0);
        end
    end

    // ---------------- quotient pipeline
    logic                  vq;
    logic [LN-1:0][DS-1:0] quo;
    logic [LN-1:0]         rem_nz;
    logic [$bits(side_t)-1:0] sbq_bits;
    side_t                 sbq;

    rgbhsv_div #(
        .DW  (CB),
        .QW  (DS),
        .SBW ($bits(side_t))
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .in_valid   (v3_reg),
        .in_num     (num3_reg),
        .in_den     (den3_reg),
        .in_sb      (sb3_reg),
        .out_valid  (vq),
        .out_quo    (quo),
        .out_rem_nz (rem_nz),
        .out_sb     (sbq_bits)
    );

    assign sbq = side_t'(sbq_bits);

    // ---------------- stage 4: hue offset, floor, wrap
    logic                v4_reg;
    res_t                res4_reg;
    logic signed [HW:0]  off_w, q_w, h_raw, h_wrap;
    res_t                res_w;

    always_comb begin
        unique case (sbq.sec)
            rgbhsv_pkg::SEC_RED:   off_w = '0;
            rgbhsv_pkg::SEC_GREEN: off_w = OFF_GREEN;
            rgbhsv_pkg::SEC_BLUE:  off_w = OFF_BLUE;
            default:               off_w = '0;
        endcase
        q_w = $signed((HW+1)'(quo[L_HUE]));
        // negative difference: floor = -(trunc quotient) - (remainder != 0)
        if (sbq.neg) begin
            h_raw = off_w - q_w - $signed((HW+1)'(rem_nz[L_HUE]));
        end else begin
            h_raw = off_w + q_w;
        end
        h_wrap = (h_raw < 0) ? (h_raw + WRAP) : h_raw;

        res_w.value  = VAL_W'(sbq.mx);
        res_w.achrom = sbq.gray;
        if (sbq.gray) begin
            res_w.hue = '0;
            res_w.sat = '0;
        end else begin
            res_w.hue = HUE_W'(h_wrap[HW-1:0]);
            res_w.sat = SAT_W'(quo[L_SAT]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (ce) begin
            v4_reg <= vq;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            res4_reg <= res_w;
        end
    end

    // ---------------- output register and skid buffer
    logic out_valid_reg, skid_valid_reg;
    res_t out_reg, skid_reg;
    logic out_load;

    assign ce       = !skid_valid_reg;
    assign out_load = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg  <= skid_valid_reg || v4_reg;
            skid_valid_reg <= 1'b0;
        end else if (ce && v4_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= skid_valid_reg ? skid_reg : res4_reg;
        end
        if (!out_load && ce) begin
            skid_reg <= res4_reg;
        end
    end

    assign s_axis_tready = ce;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = rgbhsv_pkg::M_TDATA_W'({out_reg.value, out_reg.sat, out_reg.hue});
    assign m_axis_tuser  = out_reg.achrom;

    // ---------------- checks
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while the output register is empty");

    a_ready_after_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input blocked without a stalled output word");

    a_gray_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata[HUE_W+SAT_W-1:0] == '0))
        else $error("achromatic word with nonzero hue or saturation");

    a_width_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[rgbhsv_pkg::M_TDATA_W-1:OUT_W] == '0))
        else $error("pad bits of output word not zero");

endmodule
